// ===== rtl/kia_pkg.sv =====
package kia_pkg;

  localparam int unsigned PIN_DIGITS = 4;
  localparam int unsigned PIN_COUNT  = 4;
  localparam int unsigned PIN_W      = 4 * PIN_DIGITS;
  localparam int unsigned CNT_W      = $clog2(PIN_DIGITS + 1);
  localparam int unsigned SLOT_W     = $clog2(PIN_COUNT);
  localparam int unsigned AVG_W      = 28;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PIN_DIGITS);

  // event kinds
  localparam logic [1:0] EV_KEY   = 2'd0;
  localparam logic [1:0] EV_ACCEL = 2'd1;
  localparam logic [1:0] EV_LIGHT = 2'd2;

  // key codes
  localparam logic [3:0] K_STAR = 4'd10;
  localparam logic [3:0] K_HASH = 4'd11;
  localparam logic [3:0] K_A    = 4'd12;
  localparam logic [3:0] K_C    = 4'd13;
  localparam logic [3:0] K_D    = 4'd14;
  localparam logic [3:0] K_NINE = 4'd9;

  // entry status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_DIGIT    = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_WRONG    = 3'd4;
  localparam logic [2:0] ST_OK       = 3'd5;

  // alarm causes
  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_MOTION = 2'd1;
  localparam logic [1:0] CAUSE_LIGHT  = 2'd2;

  // led colours
  localparam logic [1:0] LED_GREEN  = 2'd0;
  localparam logic [1:0] LED_YELLOW = 2'd1;
  localparam logic [1:0] LED_RED    = 2'd2;
  localparam logic [1:0] LED_BLUE   = 2'd3;

  // pin slots
  localparam logic [SLOT_W-1:0] SLOT_ADMIN  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_DISARM = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_ARM    = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_OFF    = SLOT_W'(3);

  localparam logic [15:0] PIN_RESET [4] = '{16'h1234, 16'h1111, 16'h2222, 16'h3333};

  // Q16 step of one light threshold unit
  localparam logic [AVG_W-1:0] LIGHT_STEP = AVG_W'(922460);
  // floor(n/100) = (n * DIV100_MAGIC) >> 37 for any 32-bit n
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;

  typedef struct packed {
    logic [PIN_W-1:0] digits;
    logic [CNT_W-1:0] count;
    logic [2:0]       st;
  } entry_t;

  function automatic entry_t entry_edit(input logic [3:0] key,
                                        input logic [PIN_W-1:0] digits,
                                        input logic [CNT_W-1:0] count);
    entry_t r;
    r.digits = digits;
    r.count  = count;
    r.st     = ST_NONE;
    if (key == K_STAR) begin
      if (count != '0) begin
        r.count  = count - CNT_W'(1);
        r.digits = digits >> 4;
      end
    end else if (key <= K_NINE) begin
      if (count >= CNT_FULL) begin
        r.st = ST_TOO_LONG;
      end else begin
        r.digits = {digits[PIN_W-5:0], key};
        r.count  = count + CNT_W'(1);
        r.st     = ST_DIGIT;
      end
    end
    return r;
  endfunction

  function automatic logic [PIN_W-1:0] pin_reset_val(input int unsigned i);
    return PIN_W'(PIN_RESET[i % 4]);
  endfunction

endpackage

// ===== rtl/kia_if.sv =====
interface kia_evt_if;
  import kia_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  key_code;
  logic signed [13:0] accel_x;
  logic signed [13:0] accel_y;
  logic signed [13:0] accel_z;
  logic [11:0] light_sample;

  modport source(output valid, mode, key_code, accel_x, accel_y, accel_z, light_sample,
                 input ready);
  modport sink(input valid, mode, key_code, accel_x, accel_y, accel_z, light_sample,
               output ready);
endinterface

interface kia_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  system_mode;
  logic [1:0]  alarm_cause;
  logic        siren_on;
  logic [1:0]  led_color;
  logic [2:0]  entry_status;
  logic [2:0]  digits_entered;
  logic [2:0]  menu_index;
  logic [11:0] light_level;

  modport source(output valid, system_mode, alarm_cause, siren_on, led_color, entry_status,
                 digits_entered, menu_index, light_level, input ready);
  modport sink(input valid, system_mode, alarm_cause, siren_on, led_color, entry_status,
               digits_entered, menu_index, light_level, output ready);
endinterface

// ===== rtl/kia_light.sv =====
module kia_light import kia_pkg::*; (
  input  logic [11:0]      sample_i,
  input  logic [AVG_W-1:0] avg_i,
  input  logic [3:0]       rate_i,
  input  logic [3:0]       thr_i,
  output logic             big_o,
  output logic [AVG_W-1:0] avg_o
);

  logic signed [AVG_W:0] diff;
  logic                  neg;
  logic [AVG_W-1:0]      mag;
  logic [31:0]           scaled;
  logic [63:0]           prod;
  logic [26:0]           delta;
  logic [AVG_W-1:0]      limit;

  always_comb begin
    diff = $signed({1'b0, sample_i, 16'b0}) - $signed({1'b0, avg_i});
    neg  = diff[AVG_W];
    mag  = neg ? AVG_W'(-diff) : AVG_W'(diff);
    // rate is four bits: shift and add
    scaled = (rate_i[0] ? 32'(mag)       : 32'd0)
           + (rate_i[1] ? 32'(mag) << 1  : 32'd0)
           + (rate_i[2] ? 32'(mag) << 2  : 32'd0)
           + (rate_i[3] ? 32'(mag) << 3  : 32'd0);
    prod  = 64'(scaled) * 64'(DIV100_MAGIC);
    delta = prod[63:37];
    limit = AVG_W'(thr_i) * LIGHT_STEP;
    big_o = AVG_W'(delta) > limit;
    avg_o = neg ? avg_i - AVG_W'(delta) : avg_i + AVG_W'(delta);
  end

endmodule

// ===== rtl/keypad_intrusion_alarm_controller.sv =====
// an accepted request's result is held in the output register from the next cycle
// throughput: one event per cycle while results are taken; the panel state is updated in the accepting cycle
// a new request is taken while the held result is being taken on the same edge
// reset (asynchronous, active low): idle mode, factory pins, default sensor settings,
// light average zero, green led, no result pending
module keypad_intrusion_alarm_controller import kia_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  kia_evt_if.sink    evt_i,
  kia_res_if.source  res_o
);

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_ARM_PIN   = 3'd1,
    MODE_ARMED     = 3'd2,
    MODE_DISARM    = 3'd3,
    MODE_ALARM     = 3'd4,
    MODE_ADMIN_PIN = 3'd5,
    MODE_MENU      = 3'd6,
    MODE_IN_MENU   = 3'd7
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [PIN_W-1:0] pw_q [PIN_COUNT];
  logic [PIN_W-1:0] pw_d [PIN_COUNT];
  logic [PIN_W-1:0] digits_q, digits_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [2:0]       menu_q, menu_d;
  logic [3:0]       lvl_q, lvl_d;
  logic             mot_en_q, mot_en_d;
  logic [3:0]       rate_q, rate_d;
  logic [3:0]       thr_q, thr_d;
  logic             light_en_q, light_en_d;
  logic [AVG_W-1:0] avg_q, avg_d;
  logic [1:0]       cause_q, cause_d;
  logic [1:0]       led_q, led_d;
  logic [2:0]       st_d, st_q;
  logic             res_valid_q;

  logic             accept;
  logic             big;
  logic [AVG_W-1:0] avg_new;

  assign evt_i.ready = !res_valid_q || res_o.ready;
  assign accept      = evt_i.valid && evt_i.ready;

  kia_light u_light (
    .sample_i (evt_i.light_sample),
    .avg_i    (avg_q),
    .rate_i   (rate_q),
    .thr_i    (thr_q),
    .big_o    (big),
    .avg_o    (avg_new)
  );

  always_comb begin
    entry_t           ed;
    logic [3:0]       key;
    logic             full;
    logic             hash;
    logic             match;
    logic [SLOT_W-1:0] slot;
    logic [13:0]      ax, ay, az;
    logic [15:0]      lim;
    logic             on;

    mode_d     = mode_q;
    pw_d       = pw_q;
    digits_d   = digits_q;
    count_d    = count_q;
    menu_d     = menu_q;
    lvl_d      = lvl_q;
    mot_en_d   = mot_en_q;
    rate_d     = rate_q;
    thr_d      = thr_q;
    light_en_d = light_en_q;
    avg_d      = avg_q;
    cause_d    = cause_q;
    led_d      = led_q;
    st_d       = ST_NONE;

    key  = evt_i.key_code;
    ed   = entry_edit(key, digits_q, count_q);
    full = count_q == CNT_FULL;
    hash = key == K_HASH;
    on   = key != 4'd0;

    unique case (mode_q)
      MODE_ARM_PIN:   slot = SLOT_ARM;
      MODE_DISARM:    slot = SLOT_DISARM;
      MODE_ALARM:     slot = SLOT_OFF;
      MODE_IN_MENU:   slot = SLOT_W'(menu_q);
      default:        slot = SLOT_ADMIN;
    endcase
    match = hash && full && (digits_q == pw_q[slot]);

    ax  = evt_i.accel_x[13] ? 14'(-evt_i.accel_x) : 14'(evt_i.accel_x);
    ay  = evt_i.accel_y[13] ? 14'(-evt_i.accel_y) : 14'(evt_i.accel_y);
    az  = evt_i.accel_z[13] ? 14'(-evt_i.accel_z) : 14'(evt_i.accel_z);
    lim = {1'b0, lvl_q, 11'b0} + 16'd2048;

    if (accept) begin
      if (evt_i.mode == EV_KEY) begin
        // pin entry modes share the check on hash and the edit otherwise
        if (mode_q == MODE_ARM_PIN || mode_q == MODE_DISARM || mode_q == MODE_ALARM ||
            mode_q == MODE_ADMIN_PIN) begin
          if (hash) begin
            st_d = match ? ST_OK : (full ? ST_WRONG : ST_SHORT);
          end else begin
            st_d     = ed.st;
            digits_d = ed.digits;
            count_d  = ed.count;
          end
        end
        unique case (mode_q)
          MODE_IDLE: begin
            if (key == K_A) begin
              mode_d = MODE_ARM_PIN; digits_d = '0; count_d = '0;
            end else if (key == K_C) begin
              mode_d = MODE_ADMIN_PIN; digits_d = '0; count_d = '0;
            end
          end
          MODE_ARM_PIN: begin
            if (match) begin
              mode_d = MODE_ARMED; led_d = LED_YELLOW;
            end else if (key == K_D) begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_ARMED: begin
            mode_d = MODE_DISARM; digits_d = '0; count_d = '0;
          end
          MODE_DISARM: begin
            if (match) begin
              mode_d = MODE_IDLE; led_d = LED_GREEN;
            end else if (key == K_D) begin
              mode_d = MODE_ARMED;
            end
          end
          MODE_ALARM: begin
            if (match) begin
              mode_d = MODE_IDLE; led_d = LED_GREEN; cause_d = CAUSE_NONE;
            end
          end
          MODE_ADMIN_PIN: begin
            if (match) begin
              mode_d = MODE_MENU; menu_d = 3'd0; led_d = LED_BLUE;
            end else if (key == K_D) begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_MENU: begin
            if (key == K_D) begin
              mode_d = MODE_IDLE; led_d = LED_GREEN;
            end else if (key >= 4'd1 && key <= 4'd7) begin
              menu_d = 3'(key - 4'd1);
            end else if (hash) begin
              mode_d = MODE_IN_MENU; digits_d = '0; count_d = '0;
            end
          end
          MODE_IN_MENU: begin
            if (menu_q < 3'd4) begin
              if (hash) begin
                if (full) begin
                  pw_d[slot] = digits_q; st_d = ST_OK; mode_d = MODE_MENU;
                end else begin
                  st_d = ST_SHORT;
                end
              end else begin
                st_d     = ed.st;
                digits_d = ed.digits;
                count_d  = ed.count;
              end
            end else if (hash) begin
              mode_d = MODE_MENU;
              if (menu_q == 3'd6) led_d = LED_BLUE;
            end else if (key <= K_NINE && menu_q <= 3'd6) begin
              if (menu_q == 3'd4) begin
                mot_en_d = on;
                if (on) lvl_d = key;
              end else begin
                light_en_d = on;
                if (on) begin
                  if (menu_q == 3'd5) rate_d = key;
                  else thr_d = key;
                end
              end
            end
          end
          default: ;
        endcase
      end else if (evt_i.mode == EV_ACCEL) begin
        if ((mode_q == MODE_ARMED || mode_q == MODE_DISARM) && mot_en_q &&
            ({2'b0, ax} > lim || {2'b0, ay} > lim || {2'b0, az} > lim)) begin
          mode_d = MODE_ALARM; digits_d = '0; count_d = '0;
          led_d = LED_RED; cause_d = CAUSE_MOTION;
        end
      end else if (evt_i.mode == EV_LIGHT && light_en_q) begin
        if (mode_q == MODE_ARM_PIN) begin
          avg_d = avg_new;
        end else if (mode_q == MODE_ARMED || mode_q == MODE_DISARM) begin
          if (big) begin
            mode_d = MODE_ALARM; digits_d = '0; count_d = '0;
            led_d = LED_RED; cause_d = CAUSE_LIGHT;
          end else begin
            avg_d = avg_new;
          end
        end else if (mode_q == MODE_IN_MENU && (menu_q == 3'd5 || menu_q == 3'd6)) begin
          led_d = big ? LED_RED : LED_BLUE;
          avg_d = avg_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      for (int i = 0; i < PIN_COUNT; i++) pw_q[i] <= pin_reset_val(i);
      digits_q    <= '0;
      count_q     <= '0;
      menu_q      <= 3'd0;
      lvl_q       <= 4'd2;
      mot_en_q    <= 1'b1;
      rate_q      <= 4'd9;
      thr_q       <= 4'd1;
      light_en_q  <= 1'b1;
      avg_q       <= '0;
      cause_q     <= CAUSE_NONE;
      led_q       <= LED_GREEN;
      st_q        <= ST_NONE;
      res_valid_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      pw_q       <= pw_d;
      digits_q   <= digits_d;
      count_q    <= count_d;
      menu_q     <= menu_d;
      lvl_q      <= lvl_d;
      mot_en_q   <= mot_en_d;
      rate_q     <= rate_d;
      thr_q      <= thr_d;
      light_en_q <= light_en_d;
      avg_q      <= avg_d;
      cause_q    <= cause_d;
      led_q      <= led_d;
      if (accept) begin
        st_q        <= st_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // state only moves on accept, so the result reads the live registers
  assign res_o.valid          = res_valid_q;
  assign res_o.system_mode    = mode_q;
  assign res_o.alarm_cause    = cause_q;
  assign res_o.siren_on       = mode_q == MODE_ALARM;
  assign res_o.led_color      = led_q;
  assign res_o.entry_status   = st_q;
  assign res_o.digits_entered = 3'(count_q);
  assign res_o.menu_index     = menu_q;
  assign res_o.light_level    = avg_q[AVG_W-1:16];

`ifndef NO_ASSERTIONS
  a_cause_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cause_q != CAUSE_NONE) == (mode_q == MODE_ALARM))
    else $error("alarm cause out of step with alarm mode");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("entry count beyond pin length");
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(mode_q) && $stable(avg_q) && $stable(count_q))
    else $error("panel state moved without a request");
  a_alarm_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_ALARM |-> led_q == LED_RED)
    else $error("alarm mode without red led");
`endif

endmodule

// ===== tb/keypad_intrusion_alarm_controller_checker.sv =====
`timescale 1ns / 1ps

module keypad_intrusion_alarm_controller_checker import kia_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  kia_evt_if               evt_i,
  kia_res_if               res_i,
  output int               errors_o,
  output int               pending_o,
  output logic [2:0]       mode_o,
  output logic [2:0]       menu_o,
  output logic [2:0]       count_o,
  output logic [15:0]      digits_o,
  output logic [11:0]      level_o,
  output logic [3:0][15:0] pins_o
);

  typedef struct packed {
    logic [2:0]  system_mode;
    logic [1:0]  alarm_cause;
    logic        siren_on;
    logic [1:0]  led_color;
    logic [2:0]  entry_status;
    logic [2:0]  digits_entered;
    logic [2:0]  menu_index;
    logic [11:0] light_level;
  } panel_view_t;

  panel_view_t panel_views_q[$];

  logic [2:0]  panel_mode;
  logic [15:0] pin_slots [4];
  logic [15:0] entry_digits;
  logic [2:0]  entry_count;
  logic [2:0]  menu_sel;
  logic [3:0]  motion_level;
  logic        motion_on;
  logic [3:0]  light_rate;
  logic [3:0]  light_thresh;
  logic        light_on;
  longint      light_avg;
  logic [1:0]  trip_cause;
  logic [1:0]  led;
  int          errors;

  assign errors_o  = errors;
  assign pending_o = panel_views_q.size();
  assign mode_o    = panel_mode;
  assign menu_o    = menu_sel;
  assign count_o   = entry_count;
  assign digits_o  = entry_digits;
  assign level_o   = light_avg[27:16];
  always_comb begin
    for (int i = 0; i < 4; i++) pins_o[i] = pin_slots[i];
  end

  task automatic edit_entry(input logic [3:0] key, output logic [2:0] st);
    st = ST_NONE;
    if (key == K_STAR) begin
      if (entry_count != 0) begin
        entry_count--;
        entry_digits = entry_digits >> 4;
      end
    end else if (key <= K_NINE) begin
      if (entry_count >= CNT_FULL) begin
        st = ST_TOO_LONG;
      end else begin
        entry_digits = {entry_digits[11:0], key};
        entry_count++;
        st = ST_DIGIT;
      end
    end
  endtask

  task automatic match_pin(input logic [3:0] key, input logic [1:0] slot,
                           output logic [2:0] st, output logic ok);
    ok = 1'b0;
    if (key == K_HASH) begin
      if (entry_count == CNT_FULL) begin
        ok = entry_digits == pin_slots[slot];
        st = ok ? ST_OK : ST_WRONG;
      end else begin
        st = ST_SHORT;
      end
    end else begin
      edit_entry(key, st);
    end
  endtask

  task automatic trip(input logic [1:0] cause);
    panel_mode   = 3'd4;
    entry_digits = '0;
    entry_count  = '0;
    led          = LED_RED;
    trip_cause   = cause;
  endtask

  task automatic handle_key(input logic [3:0] key, output logic [2:0] st);
    logic ok;
    st = ST_NONE;
    case (panel_mode)
      3'd0: begin
        if (key == K_A || key == K_C) begin
          panel_mode   = (key == K_A) ? 3'd1 : 3'd5;
          entry_digits = '0;
          entry_count  = '0;
        end
      end
      3'd1: begin
        match_pin(key, SLOT_ARM, st, ok);
        if (ok) begin
          panel_mode = 3'd2;
          led        = LED_YELLOW;
        end else if (key == K_D) panel_mode = 3'd0;
      end
      3'd2: begin
        panel_mode   = 3'd3;
        entry_digits = '0;
        entry_count  = '0;
      end
      3'd3: begin
        match_pin(key, SLOT_DISARM, st, ok);
        if (ok) begin
          panel_mode = 3'd0;
          led        = LED_GREEN;
        end else if (key == K_D) panel_mode = 3'd2;
      end
      3'd4: begin
        match_pin(key, SLOT_OFF, st, ok);
        if (ok) begin
          panel_mode = 3'd0;
          led        = LED_GREEN;
          trip_cause = CAUSE_NONE;
        end
      end
      3'd5: begin
        match_pin(key, SLOT_ADMIN, st, ok);
        if (ok) begin
          panel_mode = 3'd6;
          menu_sel   = '0;
          led        = LED_BLUE;
        end else if (key == K_D) panel_mode = 3'd0;
      end
      3'd6: begin
        if (key == K_D) begin
          panel_mode = 3'd0;
          led        = LED_GREEN;
        end else if (key >= 4'd1 && key <= 4'd7) begin
          menu_sel = 3'(key - 4'd1);
        end else if (key == K_HASH) begin
          panel_mode   = 3'd7;
          entry_digits = '0;
          entry_count  = '0;
        end
      end
      default: begin
        if (menu_sel < 3'd4) begin
          if (key == K_HASH) begin
            if (entry_count == CNT_FULL) begin
              pin_slots[menu_sel[1:0]] = entry_digits;
              st         = ST_OK;
              panel_mode = 3'd6;
            end else begin
              st = ST_SHORT;
            end
          end else begin
            edit_entry(key, st);
          end
        end else if (key == K_HASH) begin
          panel_mode = 3'd6;
          if (menu_sel == 3'd6) led = LED_BLUE;
        end else if (key <= K_NINE && menu_sel <= 3'd6) begin
          if (menu_sel == 3'd4) begin
            motion_on = key != 0;
            if (key != 0) motion_level = key;
          end else begin
            light_on = key != 0;
            if (key != 0) begin
              if (menu_sel == 3'd5) light_rate = key;
              else light_thresh = key;
            end
          end
        end
      end
    endcase
  endtask

  function automatic int magnitude(input logic signed [13:0] a);
    int v;
    v = a;
    return v < 0 ? -v : v;
  endfunction

  task automatic apply_event(output panel_view_t view);
    logic [2:0] st;
    int         lim;
    longint     diff, mag, d, delta;
    logic       big;
    st = ST_NONE;
    if (evt_i.mode == EV_KEY) begin
      handle_key(evt_i.key_code, st);
    end else if (evt_i.mode == EV_ACCEL) begin
      if ((panel_mode == 3'd2 || panel_mode == 3'd3) && motion_on) begin
        lim = (int'(motion_level) + 1) * 2048;
        if (magnitude(evt_i.accel_x) > lim || magnitude(evt_i.accel_y) > lim ||
            magnitude(evt_i.accel_z) > lim) trip(CAUSE_MOTION);
      end
    end else if (evt_i.mode == EV_LIGHT && light_on) begin
      diff  = (longint'(evt_i.light_sample) <<< 16) - light_avg;
      mag   = diff < 0 ? -diff : diff;
      d     = (mag * longint'(light_rate)) / 100;
      delta = diff < 0 ? -d : d;
      big   = d > longint'(light_thresh) * 922460;
      if (panel_mode == 3'd1) begin
        light_avg += delta;
      end else if (panel_mode == 3'd2 || panel_mode == 3'd3) begin
        if (big) trip(CAUSE_LIGHT);
        else light_avg += delta;
      end else if (panel_mode == 3'd7 && (menu_sel == 3'd5 || menu_sel == 3'd6)) begin
        led = big ? LED_RED : LED_BLUE;
        light_avg += delta;
      end
    end
    view.system_mode    = panel_mode;
    view.alarm_cause    = trip_cause;
    view.siren_on       = panel_mode == 3'd4;
    view.led_color      = led;
    view.entry_status   = st;
    view.digits_entered = entry_count;
    view.menu_index     = menu_sel;
    view.light_level    = light_avg[27:16];
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    panel_view_t want, view;
    if (!rst_ni) begin
      panel_mode   <= 3'd0;
      for (int i = 0; i < 4; i++) pin_slots[i] <= PIN_RESET[i];
      entry_digits <= '0;
      entry_count  <= '0;
      menu_sel     <= '0;
      motion_level <= 4'd2;
      motion_on    <= 1'b1;
      light_rate   <= 4'd9;
      light_thresh <= 4'd1;
      light_on     <= 1'b1;
      light_avg    <= 0;
      trip_cause   <= CAUSE_NONE;
      led          <= LED_GREEN;
      errors       <= 0;
      panel_views_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (panel_views_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = panel_views_q.pop_front();
          check_field("system_mode", want.system_mode, res_i.system_mode);
          check_field("alarm_cause", want.alarm_cause, res_i.alarm_cause);
          check_field("siren_on", want.siren_on, res_i.siren_on);
          check_field("led_color", want.led_color, res_i.led_color);
          check_field("entry_status", want.entry_status, res_i.entry_status);
          check_field("digits_entered", want.digits_entered, res_i.digits_entered);
          check_field("menu_index", want.menu_index, res_i.menu_index);
          check_field("light_level", want.light_level, res_i.light_level);
        end
      end
      if (evt_i.valid && evt_i.ready) begin
        apply_event(view);
        panel_views_q.push_back(view);
      end
    end
  end

endmodule

// ===== tb/keypad_intrusion_alarm_controller_test.sv =====
`timescale 1ns / 1ps

module keypad_intrusion_alarm_controller_test;
  import kia_pkg::*;

  localparam int NUM_RANDOM = 750;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [1:0]         kind;
    logic [3:0]         key;
    logic signed [13:0] ax, ay, az;
    logic [11:0]        lux;
  } panel_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic calm = 1'b0;

  int              errors, pending, stall_cycles;
  logic [2:0]      mode, menu, count;
  logic [15:0]     digits;
  logic [11:0]     level;
  logic [3:0][15:0] pins;

  kia_evt_if evt ();
  kia_res_if res ();

  keypad_intrusion_alarm_controller dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt),
    .res_o (res)
  );

  keypad_intrusion_alarm_controller_checker chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_i    (evt),
    .res_i    (res),
    .errors_o (errors),
    .pending_o(pending),
    .mode_o   (mode),
    .menu_o   (menu),
    .count_o  (count),
    .digits_o (digits),
    .level_o  (level),
    .pins_o   (pins)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) res.ready <= calm || ($urandom_range(0, 99) >= 15);

  always @(posedge clk_i) begin
    if ((evt.valid && evt.ready) || (res.valid && res.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (rst_ni && stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // caller is at a falling edge; drives the request and waits for it to be taken
  task automatic drive(input panel_event_t e);
    evt.valid        <= 1'b1;
    evt.mode         <= e.kind;
    evt.key_code     <= e.key;
    evt.accel_x      <= e.ax;
    evt.accel_y      <= e.ay;
    evt.accel_z      <= e.az;
    evt.light_sample <= e.lux;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 15) begin
      evt.valid <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic panel_event_t any_event();
    panel_event_t e;
    e.kind = 2'($urandom_range(0, 2));
    e.key  = 4'($urandom_range(0, 15));
    e.ax   = 14'($urandom_range(0, 16383));
    e.ay   = 14'($urandom_range(0, 16383));
    e.az   = 14'($urandom_range(0, 16383));
    e.lux  = 12'($urandom_range(0, 4095));
    return e;
  endfunction

  task automatic send(input logic [1:0] kind, input logic [3:0] key,
                      input int ax, input int ay, input int az, input int lux);
    panel_event_t e;
    e.kind = kind;
    e.key  = key;
    e.ax   = 14'(ax);
    e.ay   = 14'(ay);
    e.az   = 14'(az);
    e.lux  = 12'(lux);
    idle_gap();
    drive(e);
  endtask

  function automatic logic [3:0] pin_key(input logic [15:0] pin);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return K_STAR;
    if (r < 9) return K_HASH;
    if (r < 12) return K_D;
    if (r < 20) return 4'($urandom_range(0, 9));
    if (count == CNT_FULL) return (digits == pin) ? K_HASH : K_STAR;
    return pin[4 * (3 - count) +: 4];
  endfunction

  // sensor sample mostly near the thresholds that matter
  function automatic panel_event_t sample_event();
    panel_event_t e;
    int l;
    e = any_event();
    e.kind = $urandom_range(0, 1) ? EV_ACCEL : EV_LIGHT;
    if ($urandom_range(0, 99) < 75) begin
      e.ax = 14'(int'($urandom_range(0, 12000)) - 6000);
      e.ay = 14'(int'($urandom_range(0, 12000)) - 6000);
      e.az = 14'(int'($urandom_range(0, 12000)) - 6000);
      l = int'(level) + int'($urandom_range(0, 600)) - 300;
      e.lux = 12'(l < 0 ? 0 : (l > 4095 ? 4095 : l));
    end
    return e;
  endfunction

  // steer towards well-formed key sequences using the predicted panel state
  function automatic panel_event_t pick_event();
    panel_event_t e;
    int r;
    e = any_event();
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 10) return e;
    e.kind = EV_KEY;
    case (mode)
      3'd0: begin
        if (r < 45) e.key = K_A;
        else if (r < 75) e.key = K_C;
        else e = sample_event();
      end
      3'd1, 3'd3, 3'd4, 3'd5: begin
        if (r < 75) begin
          case (mode)
            3'd1: e.key = pin_key(pins[SLOT_ARM]);
            3'd3: e.key = pin_key(pins[SLOT_DISARM]);
            3'd4: e.key = pin_key(pins[SLOT_OFF]);
            default: e.key = pin_key(pins[SLOT_ADMIN]);
          endcase
        end else e = sample_event();
      end
      3'd2: if (r >= 30) e = sample_event();
      3'd6: begin
        if (r < 60) e.key = 4'($urandom_range(1, 7));
        else if (r < 90) e.key = K_HASH;
        else e.key = K_D;
      end
      default: begin
        if (menu < 3'd4) begin
          if (r < 10) e.key = K_STAR;
          else if (count == CNT_FULL) e.key = K_HASH;
          else e.key = 4'($urandom_range(0, 9));
        end else if (r < 50) e.key = 4'($urandom_range(0, 9));
        else if (r < 75) e.key = K_HASH;
        else e = sample_event();
      end
    endcase
    return e;
  endfunction

  initial begin
    int calm_start;
    panel_event_t e;
    evt.valid = 1'b0;
    evt.mode = EV_KEY;
    evt.key_code = '0;
    evt.accel_x = '0;
    evt.accel_y = '0;
    evt.accel_z = '0;
    evt.light_sample = '0;
    res.ready = 1'b0;
    stall_cycles = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // ignored keys and sample in idle, then arm with too long and too short entry
    send(EV_KEY, 4'd15, 0, 0, 0, 0);
    send(EV_KEY, 4'd0, 0, 0, 0, 0);
    send(EV_KEY, K_NINE, 0, 0, 0, 0);
    send(EV_KEY, K_STAR, 0, 0, 0, 0);
    send(EV_KEY, K_HASH, 0, 0, 0, 0);
    send(EV_KEY, K_D, 0, 0, 0, 0);
    send(EV_LIGHT, 4'd0, 0, 0, 0, 4095);
    send(EV_KEY, K_A, 0, 0, 0, 0);
    send(EV_LIGHT, 4'd0, 0, 0, 0, 4095);
    send(EV_KEY, K_HASH, 0, 0, 0, 0);
    repeat (5) send(EV_KEY, 4'd2, 0, 0, 0, 0);
    send(EV_KEY, K_STAR, 0, 0, 0, 0);
    send(EV_KEY, K_HASH, 0, 0, 0, 0);
    send(EV_KEY, 4'd2, 0, 0, 0, 0);
    send(EV_KEY, K_HASH, 0, 0, 0, 0);
    // armed: accel extremes, the negative one trips
    send(EV_ACCEL, 4'd0, 0, 0, 0, 0);
    send(EV_ACCEL, 4'd0, 0, -8192, 0, 0);
    send(EV_ACCEL, 4'd0, 8191, 0, 0, 0);
    send(EV_LIGHT, 4'd0, 0, 0, 0, 0);
    repeat (4) send(EV_KEY, 4'd3, 0, 0, 0, 0);
    send(EV_KEY, K_HASH, 0, 0, 0, 0);

    calm_start = $urandom_range(250, 450);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= calm_start && n < calm_start + 150);
      if (n == 200) begin
        @(negedge clk_i);
        evt.valid <= 1'b0;
        wait (pending == 0);
      end
      idle_gap();
      e = pick_event();
      drive(e);
    end
    calm = 1'b0;
    @(negedge clk_i);
    evt.valid <= 1'b0;
    wait (pending == 0);
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kia_pkg.sv
rtl/kia_if.sv
rtl/kia_light.sv
rtl/keypad_intrusion_alarm_controller.sv
tb/keypad_intrusion_alarm_controller_checker.sv
tb/keypad_intrusion_alarm_controller_test.sv
